// ----- sv/linear_probe_hash_index_assert.svh -----
// assertion helpers shared by the hash index rtl
`ifndef LINEAR_PROBE_HASH_INDEX_ASSERT_SVH
`define LINEAR_PROBE_HASH_INDEX_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LPHI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define LPHI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lphi_pkg.sv -----
package lphi_pkg;

    localparam int TABLE_DEPTH     = 1024;
    localparam int ENTRY_WIDTH     = 16;
    localparam int SLOT_W          = $clog2(TABLE_DEPTH);
    localparam int KEY_W           = 64;
    localparam int MIN_BITS        = 8;
    localparam int MAX_BITS        = 10;
    localparam int HASH_BITS_RESET = 8;

    typedef logic [SLOT_W-1:0] t_slot_idx;

    localparam t_slot_idx SLOT_LAST = t_slot_idx'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic                   occupied;
        logic                   removed;
        logic [KEY_W-1:0]       key;
        logic [ENTRY_WIDTH-1:0] entry;
    } t_slot;

    typedef struct packed {
        logic      we;
        t_slot_idx waddr;
        t_slot     wdata;
        logic      re;
        t_slot_idx raddr;
    } t_ram_req;

    // slot mask for a hash_bits value, clamped to the supported range
    function automatic t_slot_idx slot_mask(input logic [3:0] hb);
        int b;
        b = int'(hb);
        if (b < MIN_BITS) b = MIN_BITS;
        if (b > MAX_BITS) b = MAX_BITS;
        if (b > SLOT_W) b = SLOT_W;
        return t_slot_idx'((64'd1 << b) - 64'd1);
    endfunction

endpackage

// ----- sv/lphi_if.sv -----
interface lphi_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] name_hash;
    logic [15:0] entry_number;
    logic        force_req;

    modport source (output valid, action, name_hash, entry_number, force_req, input ready);
    modport sink   (input valid, action, name_hash, entry_number, force_req, output ready);
endinterface

interface lphi_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] found_entry;
    logic [9:0]  slot_used_at;

    modport source (output valid, status, found_entry, slot_used_at, input ready);
    modport sink   (input valid, status, found_entry, slot_used_at, output ready);
endinterface

// ----- sv/lphi_slot_ram.sv -----
module lphi_slot_ram (
    input  logic              i_clk,
    input  lphi_pkg::t_ram_req i_ram_req,
    output lphi_pkg::t_slot    o_rd_data
);
    import lphi_pkg::*;

    t_slot r_mem [TABLE_DEPTH];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ram_req.we) begin
            r_mem[i_ram_req.waddr] <= i_ram_req.wdata;
        end
        if (i_ram_req.re) begin
            r_rd_data <= r_mem[i_ram_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/linear_probe_hash_index.sv -----
// Hash index over a 1024-slot table with linear probing. One request is worked at a time:
// the slot memory is read once per probe and its registered data is judged the next cycle,
// and when a request finishes, its result waits in an output register while the next
// request is taken. A clear request sweeps all 1024 slots, one per cycle, before its result;
// after reset the same sweep runs and no request is accepted until it ends (writes of
// hash_bits are taken at any time). Writing hash_bits does not clear the table.
`include "linear_probe_hash_index_assert.svh"

module linear_probe_hash_index (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lphi_req_if.sink   i_req,
    lphi_rsp_if.source o_rsp,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data
);
    import lphi_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EVAL,
        S_CLEAR,
        S_DONE
    } t_state_e;

    t_state_e               r_state;
    logic [3:0]             r_hash_bits;
    t_action                r_action;
    logic [KEY_W-1:0]       r_key;
    logic [ENTRY_WIDTH-1:0] r_entry;
    logic                   r_force;
    t_slot_idx              r_mask;
    t_slot_idx              r_addr;
    t_slot_idx              r_count;
    logic                   r_conflict;
    t_status                r_res_status;
    logic [ENTRY_WIDTH-1:0] r_res_entry;
    t_slot_idx              r_res_slot;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [ENTRY_WIDTH-1:0] r_out_entry;
    t_slot_idx              r_out_slot;

    t_ram_req  ram_req;
    t_slot     rd_slot;
    t_slot_idx cur_mask;
    t_slot_idx home;
    t_slot_idx next_addr;
    logic      accept;
    logic      key_hit;
    logic      in_sweep;
    logic      ev_done;
    logic      ev_write;
    logic      ev_conflict;
    t_slot     ev_wdata;
    t_status   ev_status;
    logic [ENTRY_WIDTH-1:0] ev_entry;
    t_slot_idx ev_slot;

    lphi_slot_ram u_slot_ram (
        .i_clk     (i_clk),
        .i_ram_req (ram_req),
        .o_rd_data (rd_slot)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign cur_mask    = slot_mask(r_hash_bits);
    assign home        = i_req.name_hash[SLOT_W-1:0] & cur_mask;
    assign next_addr   = (r_addr + t_slot_idx'(1)) & r_mask;
    assign key_hit     = (rd_slot.key == r_key);
    assign in_sweep    = (r_state == S_INIT) || (r_state == S_CLEAR);

    // judge the slot just read
    always_comb begin
        ev_done     = 1'b0;
        ev_write    = 1'b0;
        ev_conflict = 1'b0;
        ev_wdata    = rd_slot;
        ev_status   = ST_OK;
        ev_entry    = '0;
        ev_slot     = '0;
        if (r_action == ACT_INSERT) begin
            if (!rd_slot.occupied) begin
                ev_done  = 1'b1;
                ev_write = 1'b1;
                ev_wdata = '{occupied: 1'b1, removed: 1'b0, key: r_key, entry: r_entry};
                ev_status = r_conflict ? ST_DUPLICATE : ST_OK;
                ev_slot  = r_addr;
            end else if (!rd_slot.removed && key_hit) begin
                if (!r_force) begin
                    ev_done   = 1'b1;
                    ev_status = ST_DUPLICATE;
                    ev_slot   = r_addr;
                end else begin
                    ev_conflict = 1'b1;
                end
            end
        end else begin
            if (!rd_slot.occupied) begin
                ev_done   = 1'b1;
                ev_status = ST_NOT_FOUND;
            end else if (key_hit) begin
                ev_done = 1'b1;
                if (rd_slot.removed) begin
                    ev_status = ST_NOT_FOUND;
                end else begin
                    ev_status = ST_OK;
                    ev_entry  = rd_slot.entry;
                    ev_slot   = r_addr;
                    if (r_action == ACT_DELETE) begin
                        ev_write         = 1'b1;
                        ev_wdata.removed = 1'b1;
                    end
                end
            end
        end
        // whole probe cycle gone without a decision
        if (!ev_done && r_count == r_mask) begin
            ev_done   = 1'b1;
            ev_status = ST_FULL;
            ev_slot   = '0;
        end
    end

    always_comb begin
        ram_req       = '0;
        ram_req.waddr = r_addr;
        unique case (r_state)
            S_IDLE: begin
                ram_req.re    = accept;
                ram_req.raddr = home;
            end
            S_EVAL: begin
                ram_req.we    = ev_write;
                ram_req.wdata = ev_wdata;
                ram_req.re    = !ev_done;
                ram_req.raddr = next_addr;
            end
            S_INIT, S_CLEAR: begin
                ram_req.we = 1'b1;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            r_hash_bits <= 4'(HASH_BITS_RESET);
        end else begin
            if (i_cfg_we) begin
                r_hash_bits <= i_cfg_data;
            end
            // in S_DONE the output register is refilled on the same handshake
            if (o_rsp.valid && o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + t_slot_idx'(1);
                    if (r_addr == SLOT_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_action   <= t_action'(i_req.action);
                        r_key      <= i_req.name_hash;
                        r_entry    <= ENTRY_WIDTH'(i_req.entry_number);
                        r_force    <= i_req.force_req;
                        r_mask     <= cur_mask;
                        r_count    <= '0;
                        r_conflict <= 1'b0;
                        if (t_action'(i_req.action) == ACT_CLEAR) begin
                            r_addr  <= '0;
                            r_state <= S_CLEAR;
                        end else begin
                            r_addr  <= home;
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    if (ev_done) begin
                        r_res_status <= ev_status;
                        r_res_entry  <= ev_entry;
                        r_res_slot   <= ev_slot;
                        r_state      <= S_DONE;
                    end else begin
                        r_addr  <= next_addr;
                        r_count <= r_count + t_slot_idx'(1);
                        if (ev_conflict) begin
                            r_conflict <= 1'b1;
                        end
                    end
                end
                S_CLEAR: begin
                    r_addr <= r_addr + t_slot_idx'(1);
                    if (r_addr == SLOT_LAST) begin
                        r_res_status <= ST_OK;
                        r_res_entry  <= '0;
                        r_res_slot   <= '0;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_entry  <= r_res_entry;
                        r_out_slot   <= r_res_slot;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.found_entry  = 16'(r_out_entry);
    assign o_rsp.slot_used_at = 10'(r_out_slot);

    `LPHI_ASSERT_IMPL(a_no_accept_in_sweep, in_sweep, !i_req.ready, "transaction in sweep")
    `LPHI_ASSERT_IMPL(a_write_busy, ram_req.we, in_sweep || r_state == S_EVAL, "stray write")
    `LPHI_ASSERT_NEXT(a_start, accept, r_state == S_EVAL || r_state == S_CLEAR, "no start")
    `LPHI_ASSERT_IMPL(a_count_bound, r_state == S_EVAL, r_count <= r_mask, "probe count high")
    `LPHI_ASSERT_IMPL(a_addr_bound, r_state == S_EVAL, r_addr == (r_addr & r_mask), "off table")

endmodule
